// ===== src/bapq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block absmax quantizer package
// Shared defaults, the shift width and the clamp limit of the shared exponent.
// ----------------------------------------------------------------------------
package bapq_pkg;

   localparam int LANES_DEF    = 8;
   localparam int IN_BITS_DEF  = 23;
   localparam int OUT_BITS_DEF = 8;

   // largest shared shift; the shift field is as wide as this needs
   localparam int SHIFT_LIMIT = 15;
   localparam int SHIFT_W     = 4;

   typedef logic [SHIFT_W-1:0] shift_type;

endpackage : bapq_pkg
`default_nettype wire

// ===== src/block_absmax_power2_quantizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block absmax power-of-two quantizer
// Each beat on the req_ channel carries one tile of LANES signed activations.
// The block finds the largest magnitude, picks a shared power-of-two shift
// (0..15) and returns the rounded, saturated lanes with that shift on rsp_.
// req_tlast travels unchanged to rsp_tlast with its tile.
// Path: a beat accepted on req_ passes through the input register, then the
// result register, before it appears on rsp_.
// Throughput: one tile per cycle while rsp_tready stays high, set by the single
// pass of logic between the input register and the result register.
// The input register takes a beat when empty, or when its tile moves on to the
// result register, which must be free or being drained in the same cycle.
// If rsp_tready stays low both registers fill and req_tready falls; results
// are held and none is lost or repeated.
// Reset (synchronous, active high) empties both registers by clearing their
// valid flags; the data they hold is not reset.
// ----------------------------------------------------------------------------
module block_absmax_power2_quantizer
   import bapq_pkg::*;
#(
   parameter int LANES    = LANES_DEF,
   parameter int IN_BITS  = IN_BITS_DEF,
   parameter int OUT_BITS = OUT_BITS_DEF
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   // lane0 .. lane(LANES-1), IN_BITS each, from bit 0 up
   input  wire logic [((LANES*IN_BITS+7)/8)*8-1:0]               req_tdata,
   input  wire logic                                             req_tvalid,
   input  wire logic                                             req_tlast,
   output logic                                                  req_tready,
   // qout0 .. qout(LANES-1), OUT_BITS each, then shift_exp, from bit 0 up
   output logic [((LANES*OUT_BITS+SHIFT_W+7)/8)*8-1:0]           rsp_tdata,
   output logic                                                  rsp_tvalid,
   output logic                                                  rsp_tlast,
   input  wire logic                                             rsp_tready
);

   localparam int RSP_W = ((LANES*OUT_BITS+SHIFT_W+7)/8)*8;

   logic                          in_valid_ff, in_valid_in;
   logic [LANES-1:0][IN_BITS-1:0] lanes_ff;
   logic                          last_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff;
   logic                          req_fire;
   logic                          out_load;
   shift_type                     shift;
   logic [LANES-1:0][OUT_BITS-1:0] qout;

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture a beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < LANES; i++) begin
            lanes_ff[i] <= req_tdata[i*IN_BITS +: IN_BITS];
         end
         last_ff <= req_tlast;
      end
   end

   bapq_absmax #(
      .LANES    (LANES),
      .IN_BITS  (IN_BITS),
      .OUT_BITS (OUT_BITS)
   ) u_absmax (
      .lanes (lanes_ff),
      .shift (shift)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      bapq_round #(
         .IN_BITS  (IN_BITS),
         .OUT_BITS (OUT_BITS)
      ) u_round (
         .lane  (lanes_ff[g]),
         .shift (shift),
         .qout  (qout[g])
      );
   end

   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < LANES; i++) begin
         rsp_data_in[i*OUT_BITS +: OUT_BITS] = qout[i];
      end
      rsp_data_in[LANES*OUT_BITS +: SHIFT_W] = shift;
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = out_valid_ff;

endmodule : block_absmax_power2_quantizer
`default_nettype wire

// ===== src/bapq_absmax.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block absmax quantizer: shared exponent
// Derives the clamped shift from the bit length of the largest lane
// magnitude minus one, taken as the OR of every lane's magnitude minus one.
// ----------------------------------------------------------------------------
module bapq_absmax
   import bapq_pkg::*;
#(
   parameter int LANES    = LANES_DEF,
   parameter int IN_BITS  = IN_BITS_DEF,
   parameter int OUT_BITS = OUT_BITS_DEF
) (
   input  wire logic [LANES-1:0][IN_BITS-1:0] lanes,
   output shift_type                          shift
);

   // magnitude minus one per lane; a zero lane counts as zero
   logic [LANES-1:0][IN_BITS-1:0] dec;
   logic [IN_BITS-1:0]            dec_or;
   int                            blen;
   int                            shift_raw;

   // for a negative lane the magnitude minus one is its complement, which
   // also covers the most negative lane without wrapping
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (lanes[i][IN_BITS-1]) begin
            dec[i] = ~lanes[i];
         end else if (lanes[i] == '0) begin
            dec[i] = '0;
         end else begin
            dec[i] = lanes[i] - IN_BITS'(1);
         end
      end
   end

   // the bit length of the largest value equals that of the OR of all
   always_comb begin
      dec_or = '0;
      for (int i = 0; i < LANES; i++) begin
         dec_or = dec_or | dec[i];
      end
   end

   always_comb begin
      blen = 0;
      for (int b = 0; b < IN_BITS; b++) begin
         if (dec_or[b]) begin
            blen = b + 1;
         end
      end
   end

   always_comb begin
      shift_raw = blen - (OUT_BITS - 1);
      if (shift_raw < 0) begin
         shift_raw = 0;
      end
      if (shift_raw > SHIFT_LIMIT) begin
         shift_raw = SHIFT_LIMIT;
      end
      shift = SHIFT_W'(shift_raw);
   end

endmodule : bapq_absmax
`default_nettype wire

// ===== src/bapq_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block absmax quantizer: lane rounding
// Shifts one lane right by the shared exponent with round-half-up and
// saturates it to the signed output range.
// ----------------------------------------------------------------------------
module bapq_round
   import bapq_pkg::*;
#(
   parameter int IN_BITS  = IN_BITS_DEF,
   parameter int OUT_BITS = OUT_BITS_DEF
) (
   input  wire logic [IN_BITS-1:0]  lane,
   input  wire shift_type           shift,
   output logic      [OUT_BITS-1:0] qout
);

   localparam int CW = ((IN_BITS > OUT_BITS) ? IN_BITS : OUT_BITS) + 1;
   localparam logic signed [CW-1:0] QMAX = CW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
   localparam logic signed [CW-1:0] QMIN = CW'(-(64'sd1 <<< (OUT_BITS - 1)));

   logic signed [CW-1:0] ext;
   logic signed [CW-1:0] pre;
   logic signed [CW-1:0] rnd;
   logic signed [CW-1:0] val;
   shift_type            shm1;

   always_comb begin
      ext  = CW'($signed(lane));
      shm1 = shift - SHIFT_W'(1);
      // keep one fraction bit, add a half, drop it
      pre  = (ext >>> shm1) + CW'(1);
      rnd  = pre >>> 1;
      val  = (shift == '0) ? ext : rnd;
      if (val > QMAX) begin
         val = QMAX;
      end else if (val < QMIN) begin
         val = QMIN;
      end
      qout = val[OUT_BITS-1:0];
   end

endmodule : bapq_round
`default_nettype wire
